// ----- rtl/triangle_perspective_divide_assert.svh -----
// Assertion macros shared by the perspective divide RTL.
`ifndef TRIANGLE_PERSPECTIVE_DIVIDE_ASSERT_SVH
`define TRIANGLE_PERSPECTIVE_DIVIDE_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TPD_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TPD_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/tpd_pkg.sv -----
// Package with widths, limits and types of the perspective divide pipeline.
package tpd_pkg;

    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned WORD_W     = 32;
    localparam int unsigned REM_W      = WORD_W - 1;
    localparam int unsigned CMP_W      = WORD_W + FRAC_BITS;
    localparam int unsigned DIV_STEPS  = WORD_W;
    localparam int unsigned PIPE_DEPTH = DIV_STEPS + 3;
    localparam int unsigned AXES       = 3;
    localparam int unsigned VERTS      = 3;
    localparam int unsigned VERT_W     = (AXES + 1) * WORD_W;
    localparam int unsigned TDATA_W    = VERTS * VERT_W;

    localparam logic [WORD_W-1:0] POS_LIM = {1'b0, {(WORD_W - 1){1'b1}}};
    localparam logic [WORD_W-1:0] NEG_LIM = {1'b1, {(WORD_W - 1){1'b0}}};

    typedef logic [PIPE_DEPTH-1:0]        stage_mask_t;
    typedef logic [WORD_W-1:0]            word_t;
    typedef logic [AXES-1:0][WORD_W-1:0]  axes_t;

endpackage

// ----- rtl/tpd_vertex.sv -----
// Pipelined restoring divider for the x, y and z of one vertex by its w.
module tpd_vertex (
    input  logic                 aclk,
    input  tpd_pkg::stage_mask_t ld,
    input  tpd_pkg::axes_t       num_in,
    input  tpd_pkg::word_t       w_in,
    output tpd_pkg::axes_t       quo_out,
    output tpd_pkg::word_t       w_out
);
    import tpd_pkg::*;

    logic [WORD_W-1:0] mag0_reg [AXES];
    logic [AXES-1:0]   neg0_reg;
    logic              wpos0_reg;
    logic [REM_W-1:0]  w0_reg;

    logic [REM_W-1:0]  w_reg    [DIV_STEPS+1];
    logic [DIV_STEPS:0] wpos_reg;
    logic [AXES-1:0]   neg_reg  [DIV_STEPS+1];
    logic [AXES-1:0]   ovf_reg  [DIV_STEPS+1];
    logic [REM_W-1:0]  rem_reg  [DIV_STEPS+1][AXES];
    logic [WORD_W-1:0] rq_reg   [DIV_STEPS+1][AXES];

    logic [AXES-1:0]   ovf0_next;
    logic [REM_W-1:0]  rem0_next [AXES];
    logic [WORD_W-1:0] rq0_next  [AXES];
    logic [REM_W:0]    trial     [DIV_STEPS][AXES];
    logic [REM_W:0]    diff      [DIV_STEPS][AXES];
    logic              ge        [DIV_STEPS][AXES];
    logic [REM_W-1:0]  rem_next  [DIV_STEPS][AXES];
    logic [WORD_W-1:0] rq_next   [DIV_STEPS][AXES];

    logic [WORD_W-1:0] q_fin [AXES];
    axes_t             quo_next;
    axes_t             quo_reg;
    word_t             nw_next;
    word_t             nw_reg;

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            ovf0_next[a] = CMP_W'(mag0_reg[a]) >= CMP_W'({w0_reg, {FRAC_BITS{1'b0}}});
            rem0_next[a] = REM_W'(mag0_reg[a][WORD_W-1 -: FRAC_BITS]);
            rq0_next[a]  = {mag0_reg[a][WORD_W-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
        end
        for (int s = 0; s < DIV_STEPS; s++) begin
            for (int a = 0; a < AXES; a++) begin
                trial[s][a]    = {rem_reg[s][a], rq_reg[s][a][WORD_W-1]};
                diff[s][a]     = trial[s][a] - {1'b0, w_reg[s]};
                ge[s][a]       = trial[s][a] >= {1'b0, w_reg[s]};
                rem_next[s][a] = ge[s][a] ? diff[s][a][REM_W-1:0] : trial[s][a][REM_W-1:0];
                rq_next[s][a]  = {rq_reg[s][a][WORD_W-2:0], ge[s][a]};
            end
        end
    end

    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            q_fin[a] = rq_reg[DIV_STEPS][a];
            if (!wpos_reg[DIV_STEPS]) begin
                quo_next[a] = '0;
            end else if (neg_reg[DIV_STEPS][a]) begin
                if (ovf_reg[DIV_STEPS][a] || (q_fin[a] > NEG_LIM)) begin
                    quo_next[a] = NEG_LIM;
                end else begin
                    quo_next[a] = ~q_fin[a] + 1'b1;
                end
            end else begin
                if (ovf_reg[DIV_STEPS][a] || q_fin[a][WORD_W-1]) begin
                    quo_next[a] = POS_LIM;
                end else begin
                    quo_next[a] = q_fin[a];
                end
            end
        end
        nw_next = wpos_reg[DIV_STEPS] ? WORD_W'(w_reg[DIV_STEPS]) : '0;
    end

    always_ff @(posedge aclk) begin
        if (ld[0]) begin
            wpos0_reg <= !w_in[WORD_W-1] && (w_in != '0);
            w0_reg    <= w_in[REM_W-1:0];
            for (int a = 0; a < AXES; a++) begin
                neg0_reg[a] <= num_in[a][WORD_W-1];
                mag0_reg[a] <= num_in[a][WORD_W-1] ? (~num_in[a] + 1'b1) : num_in[a];
            end
        end
        if (ld[1]) begin
            w_reg[0]    <= w0_reg;
            wpos_reg[0] <= wpos0_reg;
            neg_reg[0]  <= neg0_reg;
            ovf_reg[0]  <= ovf0_next;
            for (int a = 0; a < AXES; a++) begin
                rem_reg[0][a] <= rem0_next[a];
                rq_reg[0][a]  <= rq0_next[a];
            end
        end
        for (int s = 1; s <= DIV_STEPS; s++) begin
            if (ld[s+1]) begin
                w_reg[s]    <= w_reg[s-1];
                wpos_reg[s] <= wpos_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                ovf_reg[s]  <= ovf_reg[s-1];
                for (int a = 0; a < AXES; a++) begin
                    rem_reg[s][a] <= rem_next[s-1][a];
                    rq_reg[s][a]  <= rq_next[s-1][a];
                end
            end
        end
        if (ld[PIPE_DEPTH-1]) begin
            quo_reg <= quo_next;
            nw_reg  <= nw_next;
        end
    end

    assign quo_out = quo_reg;
    assign w_out   = nw_reg;

endmodule

// ----- rtl/triangle_perspective_divide.sv -----
// Top level of the triangle perspective divide: x, y and z of three vertices over w.
// Each accepted input word passes one input stage, one range-check stage,
// 32 restoring-division stages (one quotient bit each) and one output register.
// Throughput is one triangle per cycle while m_tready is high; a stalled output
// only blocks the input once every stage holds a word, since bubbles are squeezed out.
// Synchronous active-low reset clears the stage valid bits only.
`include "triangle_perspective_divide_assert.svh"

module triangle_perspective_divide (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, c_x, c_y, c_z, c_w
    input  logic [tpd_pkg::TDATA_W-1:0]  s_tdata,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // a_nx, a_ny, a_nz, a_nw, b_nx, b_ny, b_nz, b_nw, c_nx, c_ny, c_nz, c_nw
    output logic [tpd_pkg::TDATA_W-1:0]  m_tdata
);
    import tpd_pkg::*;

    stage_mask_t vld_reg;
    stage_mask_t vld_next;
    stage_mask_t hole;
    stage_mask_t ld;

    always_comb begin
        hole = ~vld_reg;
        for (int i = 0; i < PIPE_DEPTH; i++) begin
            ld[i] = m_tready || ((hole >> i) != '0);
        end
        vld_next[0] = ld[0] ? s_tvalid : vld_reg[0];
        for (int i = 1; i < PIPE_DEPTH; i++) begin
            vld_next[i] = ld[i] ? vld_reg[i-1] : vld_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    assign s_tready = ld[0] && aresetn;
    assign m_tvalid = vld_reg[PIPE_DEPTH-1];

    for (genvar v = 0; v < VERTS; v++) begin : g_vert
        tpd_vertex u_vertex (
            .aclk    (aclk),
            .ld      (ld),
            .num_in  (s_tdata[v*VERT_W +: AXES*WORD_W]),
            .w_in    (s_tdata[v*VERT_W + AXES*WORD_W +: WORD_W]),
            .quo_out (m_tdata[v*VERT_W +: AXES*WORD_W]),
            .w_out   (m_tdata[v*VERT_W + AXES*WORD_W +: WORD_W])
        );
    end

    `TPD_ASSERT_NXT(a_word_count, aclk, aresetn, 1'b1,
        $countones(vld_reg) == $past($countones(vld_reg)) + $past(s_tvalid && s_tready)
            - $past(m_tvalid && m_tready), "Word count in the pipeline is inconsistent.")
    `TPD_ASSERT_IMP(a_full_stall, aclk, aresetn, (!m_tready && (&vld_reg)), !s_tready,
        "Input accepted while the pipeline is full and stalled.")
    `TPD_ASSERT_IMP(a_zero_w, aclk, aresetn,
        (m_tvalid && (m_tdata[AXES*WORD_W +: WORD_W] == '0)),
        (m_tdata[AXES*WORD_W-1:0] == '0), "Nonzero quotient for a vertex with zero w output.")

endmodule
